// ----- design/triangle_mesh_edge_midpoint_elevator_macros.svh -----
// Assertion macros for the triangle mesh edge midpoint elevator.
`ifndef TRIANGLE_MESH_EDGE_MIDPOINT_ELEVATOR_MACROS_SVH
`define TRIANGLE_MESH_EDGE_MIDPOINT_ELEVATOR_MACROS_SVH
`ifndef SYNTHESIS
`define TMEME_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`else
`define TMEME_ASSERT(label, clk, rst_n, prop, msg)
`endif
`ifndef SYNTHESIS
`define TMEME_ASSERT_NORST(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TMEME_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ----- design/tmeme_pkg.sv -----
// Package with types, constants, hash and averaging functions of the mesh elevator.
package tmeme_pkg;
	localparam int NodeCapacity = 65536;
	localparam int EdgeSlots = 8192;
	localparam int CoordBits = 32;
	localparam int NodeAw = $clog2(NodeCapacity);
	localparam int EdgeAw = $clog2(EdgeSlots);
	localparam int CntW = NodeAw + 1;

	localparam logic [2:0] KIND_NODE = 3'd0;
	localparam logic [2:0] KIND_CELL = 3'd1;
	localparam logic [2:0] KIND_NOT_LINEAR = 3'd2;
	localparam logic [2:0] KIND_BAD_VERTEX = 3'd3;
	localparam logic [2:0] KIND_FULL = 3'd4;
	localparam logic [2:0] KIND_BAD_LOAD = 3'd5;
	localparam logic OP_LOAD = 1'b0;

	typedef struct packed {
		logic opcode;
		logic [15:0] vert_a;
		logic [15:0] vert_b;
		logic [15:0] vert_c;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_z;
		logic [15:0] physical_tag;
		logic [15:0] material_tag;
		logic [15:0] region_tag;
		logic is_linear_triangle;
	} in_item_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [15:0] node_id;
		logic signed [31:0] mid_x;
		logic signed [31:0] mid_y;
		logic signed [31:0] mid_z;
		logic [15:0] mid_ab;
		logic [15:0] mid_bc;
		logic [15:0] mid_ca;
		logic [15:0] out_physical;
		logic [15:0] out_material;
		logic [15:0] out_region;
		logic last;
	} out_item_t;

	typedef struct packed {
		logic [CoordBits-1:0] x;
		logic [CoordBits-1:0] y;
		logic [CoordBits-1:0] z;
	} coord_t;

	typedef struct packed {
		logic valid;
		logic [15:0] lo;
		logic [15:0] hi;
		logic [CntW-1:0] mid;
	} edge_t;

	function automatic logic [EdgeAw-1:0] edge_hash(input logic [15:0] lo,
			input logic [15:0] hi);
		logic [31:0] h;
		h = (32'(lo) * 32'h9E37) ^ (32'(hi) * 32'h85EB + 32'(hi >> 5));
		return h[EdgeAw-1:0];
	endfunction

	function automatic logic [31:0] avg(input logic [CoordBits-1:0] a,
			input logic [CoordBits-1:0] b);
		logic [CoordBits:0] s;
		logic [63:0] e;
		s = {a[CoordBits-1], a} + {b[CoordBits-1], b};
		e = 64'(signed'(s[CoordBits:1]));
		return e[31:0];
	endfunction
endpackage

// ----- design/triangle_mesh_edge_midpoint_elevator.sv -----
// Top level of the triangle mesh edge midpoint elevator.
// Usage: the input channel carries node loads (opcode 0) and triangles
// (opcode 1). Node loads store coordinates with ids in load order and give
// no result unless rejected. Each triangle gives one midpoint node result for
// every new edge and ends with a cell record, or ends with one error result.
// Results leave through a one-entry output register with valid and stall.
// After reset the edge table is cleared by a pass over all EdgeSlots (8192)
// slots, during which no input is taken. A triangle is accepted, then its
// three vertices are checked in turn. Each edge is then hashed and its slots
// probed one after another; a new midpoint reads the two end nodes from the
// node store and then gives its result. The cell record comes last. The edge
// table and node store each have one read port. When the receiver stalls,
// the finished result is held and the sequencer waits.
// Items are processed one at a time; a late or over-capacity load and a
// non-linear cell give one error result.
`include "triangle_mesh_edge_midpoint_elevator_macros.svh"
module triangle_mesh_edge_midpoint_elevator (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input tmeme_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output tmeme_pkg::out_item_t out_data
);
	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_CHECK, S_VRD, S_PROBE, S_PCHK, S_NRDA, S_NRDB,
		S_NWAIT, S_NODE, S_CELL, S_ERR
	} state_t;

	state_t state_q;
	tmeme_pkg::in_item_t item_q;
	logic [tmeme_pkg::CntW-1:0] loaded_q, next_id_q;
	logic started_q;
	logic [1:0] edge_q, vchk_q;
	logic [tmeme_pkg::EdgeAw-1:0] slot_q;
	logic [tmeme_pkg::EdgeAw:0] probes_q;
	logic [15:0] mids_q [3];
	logic [2:0] err_q;
	tmeme_pkg::coord_t ca_q;
	logic [tmeme_pkg::CntW-1:0] newid_q;

	logic nwe, ewe;
	logic [tmeme_pkg::NodeAw-1:0] nwaddr, nraddr;
	tmeme_pkg::coord_t nwdata, nrdata;
	logic [tmeme_pkg::EdgeAw-1:0] ewaddr, eraddr;
	tmeme_pkg::edge_t ewdata, erdata;

	logic [15:0] ea, eb, elo, ehi, vsel;
	logic out_free;
	logic out_load;

	assign out_free = !out_valid || !out_stall;
	assign out_load = out_free
		&& (state_q == S_NODE || state_q == S_CELL || state_q == S_ERR);
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		case (edge_q)
			2'd0: begin ea = item_q.vert_a; eb = item_q.vert_b; end
			2'd1: begin ea = item_q.vert_b; eb = item_q.vert_c; end
			default: begin ea = item_q.vert_c; eb = item_q.vert_a; end
		endcase
		elo = (ea < eb) ? ea : eb;
		ehi = (ea < eb) ? eb : ea;
		case (vchk_q)
			2'd0: vsel = item_q.vert_a;
			2'd1: vsel = item_q.vert_b;
			default: vsel = item_q.vert_c;
		endcase
	end

	always_comb begin
		nwe = (state_q == S_IDLE) && in_valid && (in_data.opcode == tmeme_pkg::OP_LOAD)
			&& !started_q && (loaded_q < tmeme_pkg::CntW'(tmeme_pkg::NodeCapacity));
		nwaddr = loaded_q[tmeme_pkg::NodeAw-1:0];
		nwdata.x = in_data.coord_x[tmeme_pkg::CoordBits-1:0];
		nwdata.y = in_data.coord_y[tmeme_pkg::CoordBits-1:0];
		nwdata.z = in_data.coord_z[tmeme_pkg::CoordBits-1:0];
		nraddr = (state_q == S_NRDA) ? ea[tmeme_pkg::NodeAw-1:0] : eb[tmeme_pkg::NodeAw-1:0];
		eraddr = slot_q;
		ewe = 1'b0;
		ewaddr = slot_q;
		ewdata = '0;
		if (state_q == S_CLEAR) begin
			ewe = 1'b1;
		end else if (state_q == S_PCHK && !erdata.valid
				&& next_id_q < tmeme_pkg::CntW'(tmeme_pkg::NodeCapacity)) begin
			ewe = 1'b1;
			ewdata = '{valid: 1'b1, lo: elo, hi: ehi, mid: next_id_q};
		end
	end

	tmeme_node_ram u_node (.clk, .we(nwe), .waddr(nwaddr), .wdata(nwdata),
		.raddr(nraddr), .rdata(nrdata));
	tmeme_edge_ram u_edge (.clk, .we(ewe), .waddr(ewaddr), .wdata(ewdata),
		.raddr(eraddr), .rdata(erdata));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			loaded_q <= '0;
			next_id_q <= '0;
			started_q <= 1'b0;
			slot_q <= '0;
			out_valid <= 1'b0;
			edge_q <= '0;
			vchk_q <= '0;
			probes_q <= '0;
		end else begin
			if (out_load) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					slot_q <= slot_q + 1'b1;
					if (slot_q == tmeme_pkg::EdgeAw'(tmeme_pkg::EdgeSlots - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						item_q <= in_data;
						if (in_data.opcode == tmeme_pkg::OP_LOAD) begin
							if (nwe) begin
								loaded_q <= loaded_q + 1'b1;
								next_id_q <= next_id_q + 1'b1;
							end else begin
								err_q <= tmeme_pkg::KIND_BAD_LOAD;
								state_q <= S_ERR;
							end
						end else begin
							started_q <= 1'b1;
							vchk_q <= '0;
							edge_q <= '0;
							if (!in_data.is_linear_triangle) begin
								err_q <= tmeme_pkg::KIND_NOT_LINEAR;
								state_q <= S_ERR;
							end else state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					if (tmeme_pkg::CntW'(vsel) >= loaded_q) begin
						err_q <= tmeme_pkg::KIND_BAD_VERTEX;
						state_q <= S_ERR;
					end else if (vchk_q == 2'd2) begin
						state_q <= S_VRD;
					end else vchk_q <= vchk_q + 1'b1;
				end
				S_VRD: begin
					slot_q <= tmeme_pkg::edge_hash(elo, ehi);
					probes_q <= '0;
					state_q <= S_PROBE;
				end
				S_PROBE: state_q <= S_PCHK;
				S_PCHK: begin
					if (!erdata.valid) begin
						if (ewe) begin
							newid_q <= next_id_q;
							mids_q[edge_q] <= next_id_q[15:0];
							next_id_q <= next_id_q + 1'b1;
							state_q <= S_NRDA;
						end else begin
							err_q <= tmeme_pkg::KIND_FULL;
							state_q <= S_ERR;
						end
					end else if (erdata.lo == elo && erdata.hi == ehi) begin
						mids_q[edge_q] <= erdata.mid[15:0];
						if (edge_q == 2'd2) state_q <= S_CELL;
						else begin
							edge_q <= edge_q + 1'b1;
							state_q <= S_VRD;
						end
					end else if (probes_q == (tmeme_pkg::EdgeAw+1)'(tmeme_pkg::EdgeSlots - 1)) begin
						err_q <= tmeme_pkg::KIND_FULL;
						state_q <= S_ERR;
					end else begin
						slot_q <= slot_q + 1'b1;
						probes_q <= probes_q + 1'b1;
						state_q <= S_PROBE;
					end
				end
				S_NRDA: state_q <= S_NRDB;
				S_NRDB: begin
					ca_q <= nrdata;
					state_q <= S_NWAIT;
				end
				S_NWAIT: state_q <= S_NODE;
				S_NODE: begin
					if (out_free) begin
						out_data <= '{kind: tmeme_pkg::KIND_NODE, node_id: newid_q[15:0],
							mid_x: tmeme_pkg::avg(ca_q.x, nrdata.x),
							mid_y: tmeme_pkg::avg(ca_q.y, nrdata.y),
							mid_z: tmeme_pkg::avg(ca_q.z, nrdata.z), default: '0};
						if (edge_q == 2'd2) state_q <= S_CELL;
						else begin
							edge_q <= edge_q + 1'b1;
							state_q <= S_VRD;
						end
					end
				end
				S_CELL: begin
					if (out_free) begin
						out_data <= '{kind: tmeme_pkg::KIND_CELL, mid_ab: mids_q[0],
							mid_bc: mids_q[1], mid_ca: mids_q[2],
							out_physical: item_q.physical_tag,
							out_material: item_q.material_tag,
							out_region: item_q.region_tag, last: 1'b1, default: '0};
						state_q <= S_IDLE;
					end
				end
				S_ERR: begin
					if (out_free) begin
						out_data <= '{kind: err_q, last: 1'b1, default: '0};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`TMEME_ASSERT(a_no_accept_busy, clk, arst_n,
		(state_q != S_IDLE) |-> in_stall, "input accepted while busy")
	`TMEME_ASSERT(a_ids_ordered, clk, arst_n,
		next_id_q >= loaded_q, "next free id fell below loaded count")
	`TMEME_ASSERT(a_out_hold, clk, arst_n,
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)),
		"stalled result changed")
endmodule

// ----- design/tmeme_node_ram.sv -----
// Node coordinate memory with one write port and one registered read port.
module tmeme_node_ram (
	input logic clk,
	input logic we,
	input logic [tmeme_pkg::NodeAw-1:0] waddr,
	input tmeme_pkg::coord_t wdata,
	input logic [tmeme_pkg::NodeAw-1:0] raddr,
	output tmeme_pkg::coord_t rdata
);
	tmeme_pkg::coord_t mem [tmeme_pkg::NodeCapacity];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- design/tmeme_edge_ram.sv -----
// Edge table memory with one write port and one registered read port.
module tmeme_edge_ram (
	input logic clk,
	input logic we,
	input logic [tmeme_pkg::EdgeAw-1:0] waddr,
	input tmeme_pkg::edge_t wdata,
	input logic [tmeme_pkg::EdgeAw-1:0] raddr,
	output tmeme_pkg::edge_t rdata
);
	tmeme_pkg::edge_t mem [tmeme_pkg::EdgeSlots];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- tb/sv/triangle_mesh_edge_midpoint_elevator_tb.sv -----
// Self-checking testbench for the triangle mesh edge midpoint elevator.
module triangle_mesh_edge_midpoint_elevator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 64;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	tmeme_pkg::in_item_t in_data;
	logic out_valid;
	logic out_stall;
	tmeme_pkg::out_item_t out_data;

	triangle_mesh_edge_midpoint_elevator dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	logic signed [31:0] node_x [tmeme_pkg::NodeCapacity];
	logic signed [31:0] node_y [tmeme_pkg::NodeCapacity];
	logic signed [31:0] node_z [tmeme_pkg::NodeCapacity];
	logic slot_used [tmeme_pkg::EdgeSlots];
	logic [15:0] slot_lo [tmeme_pkg::EdgeSlots];
	logic [15:0] slot_hi [tmeme_pkg::EdgeSlots];
	logic [16:0] slot_mid [tmeme_pkg::EdgeSlots];
	logic [16:0] nodes_loaded;
	logic [16:0] next_node_id;
	logic cells_begun;

	tmeme_pkg::out_item_t expected_results[$];
	int mismatch_count = 0;
	int send_idle_pct;
	int recv_stall_pct;
	longint cycle_count = 0;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic signed [31:0] floor_mean(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic [32:0] s;
		s = {a[31], a} + {b[31], b};
		return s[32:1];
	endfunction

	function automatic tmeme_pkg::out_item_t error_result(input logic [2:0] kind);
		tmeme_pkg::out_item_t r;
		r = '0;
		r.kind = kind;
		r.last = 1'b1;
		return r;
	endfunction

	// Returns 0 on a hit, 1 when a midpoint was created, 2 when the table is full.
	function automatic int find_edge(input logic [15:0] a, input logic [15:0] b,
			output logic [16:0] mid);
		logic [15:0] lo;
		logic [15:0] hi;
		logic [31:0] h;
		int slot;
		tmeme_pkg::out_item_t r;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		h = (32'(lo) * 32'h9E37) ^ (32'(hi) * 32'h85EB + 32'(hi >> 5));
		slot = h % tmeme_pkg::EdgeSlots;
		mid = '0;
		for (int n = 0; n < tmeme_pkg::EdgeSlots; n++) begin
			if (!slot_used[slot]) begin
				if (next_node_id >= tmeme_pkg::NodeCapacity)
					return 2;
				slot_used[slot] = 1'b1;
				slot_lo[slot] = lo;
				slot_hi[slot] = hi;
				slot_mid[slot] = next_node_id;
				mid = next_node_id;
				next_node_id++;
				r = '0;
				r.kind = tmeme_pkg::KIND_NODE;
				r.node_id = mid[15:0];
				r.mid_x = floor_mean(node_x[a], node_x[b]);
				r.mid_y = floor_mean(node_y[a], node_y[b]);
				r.mid_z = floor_mean(node_z[a], node_z[b]);
				expected_results.push_back(r);
				return 1;
			end
			if (slot_lo[slot] == lo && slot_hi[slot] == hi) begin
				mid = slot_mid[slot];
				return 0;
			end
			slot = (slot + 1) % tmeme_pkg::EdgeSlots;
		end
		return 2;
	endfunction

	function automatic void elevate_item(input tmeme_pkg::in_item_t it);
		logic [15:0] v [3];
		logic [16:0] mids [3];
		tmeme_pkg::out_item_t r;
		if (it.opcode == tmeme_pkg::OP_LOAD) begin
			if (cells_begun || nodes_loaded >= tmeme_pkg::NodeCapacity) begin
				expected_results.push_back(error_result(tmeme_pkg::KIND_BAD_LOAD));
			end else begin
				node_x[nodes_loaded[15:0]] = it.coord_x;
				node_y[nodes_loaded[15:0]] = it.coord_y;
				node_z[nodes_loaded[15:0]] = it.coord_z;
				nodes_loaded++;
				next_node_id++;
			end
			return;
		end
		cells_begun = 1'b1;
		if (!it.is_linear_triangle) begin
			expected_results.push_back(error_result(tmeme_pkg::KIND_NOT_LINEAR));
			return;
		end
		v[0] = it.vert_a;
		v[1] = it.vert_b;
		v[2] = it.vert_c;
		for (int e = 0; e < 3; e++) begin
			if (v[e] >= nodes_loaded) begin
				expected_results.push_back(error_result(tmeme_pkg::KIND_BAD_VERTEX));
				return;
			end
		end
		for (int e = 0; e < 3; e++) begin
			if (find_edge(v[e], v[(e + 1) % 3], mids[e]) == 2) begin
				expected_results.push_back(error_result(tmeme_pkg::KIND_FULL));
				return;
			end
		end
		r = '0;
		r.kind = tmeme_pkg::KIND_CELL;
		r.mid_ab = mids[0][15:0];
		r.mid_bc = mids[1][15:0];
		r.mid_ca = mids[2][15:0];
		r.out_physical = it.physical_tag;
		r.out_material = it.material_tag;
		r.out_region = it.region_tag;
		r.last = 1'b1;
		expected_results.push_back(r);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at cycle %0d: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	task automatic send_item(input tmeme_pkg::in_item_t it);
		logic free;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		forever begin
			@(negedge clk);
			free = !in_stall;
			@(posedge clk);
			if (free)
				break;
		end
		elevate_item(it);
	endtask

	function automatic tmeme_pkg::in_item_t random_item();
		tmeme_pkg::in_item_t it;
		it.opcode = 1'($urandom);
		it.vert_a = 16'($urandom);
		it.vert_b = 16'($urandom);
		it.vert_c = 16'($urandom);
		it.coord_x = $urandom;
		it.coord_y = $urandom;
		it.coord_z = $urandom;
		it.physical_tag = 16'($urandom);
		it.material_tag = 16'($urandom);
		it.region_tag = 16'($urandom);
		it.is_linear_triangle = 1'($urandom);
		return it;
	endfunction

	function automatic tmeme_pkg::in_item_t load_item(input logic signed [31:0] x,
			input logic signed [31:0] y, input logic signed [31:0] z);
		tmeme_pkg::in_item_t it;
		it = random_item();
		it.opcode = tmeme_pkg::OP_LOAD;
		it.coord_x = x;
		it.coord_y = y;
		it.coord_z = z;
		return it;
	endfunction

	function automatic tmeme_pkg::in_item_t cell_item(input logic [15:0] a,
			input logic [15:0] b, input logic [15:0] c, input logic linear);
		tmeme_pkg::in_item_t it;
		it = random_item();
		it.opcode = ~tmeme_pkg::OP_LOAD;
		it.vert_a = a;
		it.vert_b = b;
		it.vert_c = c;
		it.is_linear_triangle = linear;
		return it;
	endfunction

	always @(posedge clk) begin
		tmeme_pkg::out_item_t want;
		cycle_count <= cycle_count + 1;
		out_stall <= ($urandom_range(99) < recv_stall_pct);
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("transaction with no expected result");
			end else begin
				want = expected_results.pop_front();
				if (out_data.kind !== want.kind)
					report_mismatch($sformatf("kind %0d want %0d", out_data.kind, want.kind));
				if (out_data.node_id !== want.node_id)
					report_mismatch($sformatf("node_id %h want %h", out_data.node_id,
						want.node_id));
				if (out_data.mid_x !== want.mid_x)
					report_mismatch($sformatf("mid_x %h want %h", out_data.mid_x, want.mid_x));
				if (out_data.mid_y !== want.mid_y)
					report_mismatch($sformatf("mid_y %h want %h", out_data.mid_y, want.mid_y));
				if (out_data.mid_z !== want.mid_z)
					report_mismatch($sformatf("mid_z %h want %h", out_data.mid_z, want.mid_z));
				if (out_data.mid_ab !== want.mid_ab)
					report_mismatch($sformatf("mid_ab %h want %h", out_data.mid_ab, want.mid_ab));
				if (out_data.mid_bc !== want.mid_bc)
					report_mismatch($sformatf("mid_bc %h want %h", out_data.mid_bc, want.mid_bc));
				if (out_data.mid_ca !== want.mid_ca)
					report_mismatch($sformatf("mid_ca %h want %h", out_data.mid_ca, want.mid_ca));
				if (out_data.out_physical !== want.out_physical)
					report_mismatch($sformatf("out_physical %h want %h", out_data.out_physical,
						want.out_physical));
				if (out_data.out_material !== want.out_material)
					report_mismatch($sformatf("out_material %h want %h", out_data.out_material,
						want.out_material));
				if (out_data.out_region !== want.out_region)
					report_mismatch($sformatf("out_region %h want %h", out_data.out_region,
						want.out_region));
				if (out_data.last !== want.last)
					report_mismatch($sformatf("last %b want %b", out_data.last, want.last));
			end
		end
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic test_node_loads();
		send_item(load_item(32'sh7FFFFFFF, 32'sh80000000, 32'sh00000000));
		send_item(load_item(32'sh7FFFFFFF, 32'sh80000000, 32'shFFFFFFFF));
		send_item(load_item(32'sh80000000, 32'sh7FFFFFFF, 32'sh00000001));
		send_item(load_item(32'shFFFFFFFF, 32'sh00000001, 32'sh00018000));
		send_item(load_item(32'sh00000000, 32'shFFFF0000, 32'sh0000FFFF));
	endtask

	task automatic test_random_loads(input int count);
		for (int i = 0; i < count; i++)
			send_item(load_item($urandom, $urandom, $urandom));
	endtask

	task automatic test_triangle_cases();
		tmeme_pkg::in_item_t it;
		send_item(cell_item(0, 1, 2, 1'b1));
		send_item(cell_item(2, 1, 0, 1'b1));
		send_item(cell_item(0, 2, 3, 1'b1));
		send_item(cell_item(4, 4, 4, 1'b1));
		send_item(cell_item(4, 4, 0, 1'b1));
		send_item(cell_item(0, 1, 2, 1'b0));
		send_item(cell_item(16'hFFFF, 0, 1, 1'b1));
		send_item(cell_item(0, 16'hFFFF, 1, 1'b1));
		send_item(cell_item(0, 1, 16'(nodes_loaded), 1'b1));
		it = cell_item(1, 3, 4, 1'b1);
		it.physical_tag = 16'hFFFF;
		it.material_tag = 16'h0000;
		it.region_tag = 16'hFFFF;
		send_item(it);
		it = cell_item(16'(nodes_loaded - 1), 0, 16'(nodes_loaded - 1), 1'b1);
		it.physical_tag = 16'h0000;
		it.material_tag = 16'hFFFF;
		it.region_tag = 16'h0000;
		send_item(it);
	endtask

	task automatic test_late_load();
		send_item(load_item(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
	endtask

	task automatic test_random_mix(input int count);
		tmeme_pkg::in_item_t it;
		int pick;
		int top;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			top = nodes_loaded - 1;
			if (pick < 75) begin
				it = cell_item(16'($urandom_range(top)), 16'($urandom_range(top)),
					16'($urandom_range(top)), 1'b1);
				if (pick < 8)
					it.vert_b = it.vert_a;
			end else if (pick < 84) begin
				it = random_item();
				it.opcode = ~tmeme_pkg::OP_LOAD;
				it.is_linear_triangle = 1'b0;
			end else if (pick < 92) begin
				it = cell_item(16'($urandom_range(top)), 16'($urandom_range(top)),
					16'($urandom_range(top)), 1'b1);
				case ($urandom_range(2))
					0: it.vert_a = 16'($urandom_range(65535, nodes_loaded));
					1: it.vert_b = 16'($urandom_range(65535, nodes_loaded));
					default: it.vert_c = 16'($urandom_range(65535, nodes_loaded));
				endcase
			end else if (pick < 96) begin
				it = random_item();
				it.opcode = tmeme_pkg::OP_LOAD;
			end else begin
				it = random_item();
			end
			send_item(it);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		nodes_loaded = '0;
		next_node_id = '0;
		cells_begun = 1'b0;
		for (int i = 0; i < tmeme_pkg::EdgeSlots; i++)
			slot_used[i] = 1'b0;
		send_idle_pct = 22;
		recv_stall_pct = 59;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_node_loads();
		test_random_loads(50);
		test_triangle_cases();
		test_late_load();
		test_random_mix(135);
		send_idle_pct = 59;
		recv_stall_pct = 22;
		test_random_mix(135);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random_mix(135);
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+design
design/tmeme_pkg.sv
design/tmeme_node_ram.sv
design/tmeme_edge_ram.sv
design/triangle_mesh_edge_midpoint_elevator.sv
tb/sv/triangle_mesh_edge_midpoint_elevator_tb.sv
